// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hdl/bpra_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the bitmap page range allocator. No dependencies.
package bpra_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = NUM_PAGES / WORD_BITS;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int PIDX_W     = $clog2(NUM_PAGES);
    localparam int PCNT_W     = PIDX_W + 1;
    localparam int ADDR_W     = 28;
    localparam int PSIZE_W    = 17;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int PAGE_SIZE_RST = 4096;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = 2'd2;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_bit;
        logic div_start;
        logic free_range;
        logic init_range;
        logic clear_map;
        logic mark_start;
        logic mark_rd;
        logic mark_wr;
        logic set_nospace;
        logic out_load;
    } bpra_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic count_zero;
        logic tp_zero;
        logic found;
        logic last_page;
        logic word_end;
        logic div_done;
        logic mark_empty;
        logic mark_last;
    } bpra_sts_t;

endpackage

// ===== hdl/bpra_div.sv =====
// Restoring divider, one quotient bit per cycle: address by page size.
// Depends on bpra_pkg.
module bpra_div import bpra_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ADDR_W-1:0]  dividend,
    input  logic [PSIZE_W-1:0] divisor,
    output logic [ADDR_W-1:0]  quotient,
    output logic               done
);

    localparam int CNT_W = $clog2(ADDR_W);

    logic [ADDR_W-1:0]  quo_reg;
    logic [PSIZE_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [PSIZE_W:0]   rem_shift;
    logic [PSIZE_W:0]   diff;
    logic               ge;

    assign rem_shift = {rem_reg, quo_reg[ADDR_W-1]};
    assign ge        = rem_shift >= {1'b0, divisor};
    assign diff      = rem_shift - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[ADDR_W-2:0], ge};
            rem_reg <= ge ? diff[PSIZE_W-1:0] : rem_shift[PSIZE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ADDR_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/bpra_datapath.sv =====
// Datapath: configuration, request latch, bitmap memory, scan and marking
// logic, result and output registers. Depends on bpra_pkg and bpra_div.
module bpra_datapath import bpra_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  bpra_cmd_t             cmd,
    output bpra_sts_t             sts,
    output logic [STAT_W-1:0]     out_status,
    output logic [PIDX_W-1:0]     out_first,
    output logic [ADDR_W-1:0]     out_addr
);

    logic [PSIZE_W-1:0] page_size_reg;
    logic [PCNT_W-1:0]  total_reg;
    logic [PCNT_W-1:0]  reserved_reg;
    logic [PSIZE_W-1:0] ps_eff;
    logic [PCNT_W-1:0]  tp;
    logic [PCNT_W-1:0]  resv;

    logic [REQ_W-1:0]   req_reg;
    logic [PCNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0]  saddr_reg;

    logic [PCNT_W-1:0]  page_reg;
    logic [PCNT_W-1:0]  run_reg;
    logic [PIDX_W-1:0]  run_start_reg;
    logic               bit_free;
    logic               found;
    logic [PIDX_W-1:0]  start_now;

    logic [PCNT_W-1:0]  lo_reg;
    logic [PCNT_W-1:0]  hi_reg;
    logic               mark_val_reg;
    logic [WORD_AW-1:0] word_reg;
    logic [PCNT_W-1:0]  hi_m1;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wdata;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [WORD_AW-1:0]   rd_addr;

    logic [ADDR_W-1:0]  quotient;
    logic               div_done;
    logic [ADDR_W:0]    free_end;
    logic               free_bad;

    logic [PIDX_W+PSIZE_W-1:0] prod;
    logic [STAT_W-1:0]  res_status_reg;
    logic [PIDX_W-1:0]  res_first_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [PIDX_W-1:0]  out_first_reg;
    logic [ADDR_W-1:0]  out_addr_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_size_reg <= PSIZE_W'(PAGE_SIZE_RST);
            total_reg     <= PCNT_W'(NUM_PAGES);
            reserved_reg  <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_PAGE_SIZE)   page_size_reg <= cfg_wdata;
            if (cfg_index == CFG_TOTAL_PAGES) total_reg     <= cfg_wdata[PCNT_W-1:0];
            if (cfg_index == CFG_RESERVED)    reserved_reg  <= cfg_wdata[PCNT_W-1:0];
        end
    end

    assign ps_eff = (page_size_reg == '0) ? PSIZE_W'(1) : page_size_reg;
    assign tp     = (total_reg > PCNT_W'(NUM_PAGES)) ? PCNT_W'(NUM_PAGES) : total_reg;
    assign resv   = (reserved_reg > tp) ? tp : reserved_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_tdata[REQ_W-1:0];
            count_reg <= s_tdata[REQ_W +: PCNT_W];
            saddr_reg <= s_tdata[REQ_W+PCNT_W +: ADDR_W];
        end
    end

    bpra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (saddr_reg),
        .divisor  (ps_eff),
        .quotient (quotient),
        .done     (div_done)
    );

    // first-fit scan, one page per cycle, with a word read at each word boundary
    assign bit_free  = !rdata_reg[page_reg[BIT_AW-1:0]];
    assign found     = bit_free && ((run_reg + PCNT_W'(1)) == count_reg);
    assign start_now = (run_reg == '0) ? page_reg[PIDX_W-1:0] : run_start_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            page_reg <= '0;
            run_reg  <= '0;
        end else if (cmd.scan_bit) begin
            page_reg <= page_reg + PCNT_W'(1);
            if (bit_free) begin
                run_reg <= run_reg + PCNT_W'(1);
                if (run_reg == '0) run_start_reg <= page_reg[PIDX_W-1:0];
            end else begin
                run_reg <= '0;
            end
        end
    end

    assign free_end = {1'b0, quotient} + (ADDR_W+1)'(count_reg);
    assign free_bad = (count_reg != '0) && (free_end > (ADDR_W+1)'(tp));

    // range to mark: [lo, hi) with mark_val
    always_ff @(posedge aclk) begin
        if (cmd.scan_bit && found) begin
            lo_reg       <= {1'b0, start_now};
            hi_reg       <= {1'b0, start_now} + count_reg;
            mark_val_reg <= 1'b1;
        end else if (cmd.free_range) begin
            mark_val_reg <= 1'b0;
            if (quotient >= ADDR_W'(tp)) begin
                lo_reg <= '0;
                hi_reg <= '0;
            end else begin
                lo_reg <= quotient[PCNT_W-1:0];
                hi_reg <= free_bad ? tp : free_end[PCNT_W-1:0];
            end
        end else if (cmd.init_range) begin
            lo_reg       <= '0;
            hi_reg       <= resv;
            mark_val_reg <= 1'b1;
        end
        if (cmd.mark_start) word_reg <= lo_reg[PIDX_W-1:BIT_AW];
        else if (cmd.mark_wr) word_reg <= word_reg + WORD_AW'(1);
    end

    assign hi_m1 = hi_reg - PCNT_W'(1);

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = ({1'b0, word_reg, BIT_AW'(b)} >= lo_reg) &&
                      ({1'b0, word_reg, BIT_AW'(b)} < hi_reg);
        end
    end

    assign wdata   = mark_val_reg ? (rdata_reg | mask) : (rdata_reg & ~mask);
    assign rd_addr = cmd.scan_rd ? page_reg[PIDX_W-1:BIT_AW] : word_reg;

    // bitmap store; a word never written since the last clear reads as free
    always_ff @(posedge aclk) begin
        if (cmd.mark_wr) mem[word_reg] <= wdata;
        if (cmd.scan_rd || cmd.mark_rd)
            rdata_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_map) begin
            valid_reg <= '0;
        end else if (cmd.mark_wr) begin
            valid_reg[word_reg] <= 1'b1;
        end
    end

    assign prod = lo_reg[PIDX_W-1:0] * ps_eff;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_status_reg <= ST_OK;
            res_first_reg  <= '0;
            res_addr_reg   <= '0;
        end else if (cmd.set_nospace) begin
            res_status_reg <= ST_NO_SPACE;
        end else if (cmd.free_range && free_bad) begin
            res_status_reg <= ST_BAD_RANGE;
        end else if (cmd.mark_start && req_reg == REQ_ALLOC) begin
            res_first_reg <= lo_reg[PIDX_W-1:0];
            res_addr_reg  <= prod[ADDR_W-1:0];
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_first_reg  <= res_first_reg;
            out_addr_reg   <= res_addr_reg;
        end
    end

    assign out_status = out_status_reg;
    assign out_first  = out_first_reg;
    assign out_addr   = out_addr_reg;

    assign sts.req        = req_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.tp_zero    = (tp == '0);
    assign sts.found      = found;
    assign sts.last_page  = (page_reg + PCNT_W'(1)) == tp;
    assign sts.word_end   = &page_reg[BIT_AW-1:0];
    assign sts.div_done   = div_done;
    assign sts.mark_empty = (lo_reg >= hi_reg);
    assign sts.mark_last  = (word_reg == hi_m1[PIDX_W-1:BIT_AW]);

endmodule

// ===== hdl/bpra_ctrl.sv =====
// Controller state machine: sequences scan, divide and mark phases and
// drives the stream handshakes. Depends on bpra_pkg.
module bpra_ctrl import bpra_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  bpra_sts_t sts,
    output bpra_cmd_t cmd
);

    typedef enum logic [3:0] {
        IDLE, DISPATCH, SCAN_RD, SCAN_BIT, DIV_START, DIV_WAIT, FREE_RANGE,
        INIT_CLR, MARK_START, MARK_RD, MARK_WR, DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = DISPATCH;
                end
            end
            DISPATCH: begin
                priority if (sts.req == REQ_ALLOC) begin
                    if (sts.count_zero || sts.tp_zero) begin
                        cmd.set_nospace = 1'b1;
                        state_next      = DONE;
                    end else begin
                        state_next = SCAN_RD;
                    end
                end else if (sts.req == REQ_FREE) begin
                    state_next = DIV_START;
                end else if (sts.req == REQ_INIT) begin
                    state_next = INIT_CLR;
                end else begin
                    state_next = DONE;
                end
            end
            SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = SCAN_BIT;
            end
            SCAN_BIT: begin
                cmd.scan_bit = 1'b1;
                priority if (sts.found) begin
                    state_next = MARK_START;
                end else if (sts.last_page) begin
                    cmd.set_nospace = 1'b1;
                    state_next      = DONE;
                end else if (sts.word_end) begin
                    state_next = SCAN_RD;
                end else begin
                    state_next = SCAN_BIT;
                end
            end
            DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = DIV_WAIT;
            end
            DIV_WAIT: begin
                if (sts.div_done) state_next = FREE_RANGE;
            end
            FREE_RANGE: begin
                cmd.free_range = 1'b1;
                state_next     = MARK_START;
            end
            INIT_CLR: begin
                cmd.clear_map  = 1'b1;
                cmd.init_range = 1'b1;
                state_next     = MARK_START;
            end
            MARK_START: begin
                cmd.mark_start = 1'b1;
                state_next     = sts.mark_empty ? DONE : MARK_RD;
            end
            MARK_RD: begin
                cmd.mark_rd = 1'b1;
                state_next  = MARK_WR;
            end
            MARK_WR: begin
                cmd.mark_wr = 1'b1;
                state_next  = sts.mark_last ? DONE : MARK_RD;
            end
            DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hdl/bitmap_page_range_allocator.sv =====
// First-fit bitmap page allocator over NUM_PAGES pages.
//
// Input stream s_*: one request per transaction (allocate, free, init).
// Output stream m_*: exactly one result per request, in request order.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write page size, total pages
// and reserved pages; write only while no request is in flight.
// One request is worked at a time; s_tready is high only when idle.
// Steps per request:
//   allocate: per bitmap word scanned, one read, then one page per cycle;
//             then a read and a write for each marked word.
//   free:     the 28-step address divider, then a read and a write per word.
//   init:     clear the map, then a read and a write per word of reserved pages.
//   Unknown request or zero-length allocate: straight to the result.
// The page-by-page scan and the read-modify-write of each bitmap word on
// the single memory port set the time that each request takes.
// Reset clears all pages to free at once and restores the register
// defaults. When m_tready is low a finished result waits in the output
// register; the next request may be accepted and worked meanwhile, and its
// result is held back until the earlier one has been taken.
module bitmap_page_range_allocator import bpra_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // req_type[1:0], page_count[14:2], start_address[42:15]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // status[1:0], first_page[13:2], address[41:14]
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

    bpra_cmd_t          cmd;
    bpra_sts_t          sts;
    logic [STAT_W-1:0]  out_status;
    logic [PIDX_W-1:0]  out_first;
    logic [ADDR_W-1:0]  out_addr;

    bpra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bpra_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tdata    (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (out_status),
        .out_first  (out_first),
        .out_addr   (out_addr)
    );

    assign m_tdata = {(M_TDATA_W-STAT_W-PIDX_W-ADDR_W)'(0), out_addr, out_first, out_status};

    `ASSERT_PROP(a_load_free_slot, aclk, aresetn, cmd.out_load |-> (!m_tvalid || m_tready), "result overwritten before it was taken")
    `ASSERT_NEVER(a_idle_quiet, aclk, aresetn, s_tready && (cmd.mark_wr || cmd.scan_bit), "bitmap activity while idle")
    `ASSERT_PROP(a_one_in_flight, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second request taken while busy")

endmodule
